FILE: rtl/multistage_slew_soft_clipper_assert.svh
// assertion macros used by the clipper sequencer
`ifndef MULTISTAGE_SLEW_SOFT_CLIPPER_ASSERT_SVH
`define MULTISTAGE_SLEW_SOFT_CLIPPER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define MSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/msc_pkg.sv
// shared constants, operation codes and command type of the clipper
`timescale 1ns / 1ps
package msc_pkg;

    localparam int FRAC    = 20;
    localparam int Q_PHI   = 1696632;
    localparam int Q_HARD  = 648056;
    localparam int Q_SOFT  = 400520;
    localparam int Q_ONE   = 1048576;
    localparam int Q_FOUR  = 4194304;
    localparam int STORE_W = 24;

    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_PHI   = 4'd2;
    localparam logic [3:0] OP_GAIN  = 4'd3;
    localparam logic [3:0] OP_CLAMP = 4'd4;
    localparam logic [3:0] OP_P1    = 4'd5;
    localparam logic [3:0] OP_P2    = 4'd6;
    localparam logic [3:0] OP_N1    = 4'd7;
    localparam logic [3:0] OP_N2    = 4'd8;
    localparam logic [3:0] OP_FIN1  = 4'd9;
    localparam logic [3:0] OP_FIN2  = 4'd10;
    localparam logic [3:0] OP_OUT   = 4'd11;

    localparam logic [2:0] REG_STAGE_GAIN = 3'd0;
    localparam logic [2:0] REG_GAIN_RECIP = 3'd1;
    localparam logic [2:0] REG_CEILING    = 3'd2;
    localparam logic [2:0] REG_CLIP_MODE  = 3'd3;
    localparam logic [2:0] REG_SPACING    = 3'd4;

    localparam logic [3:0] MODE_GAIN_MATCH = 4'd2;
    localparam logic [3:0] MODE_OVERSHOOT  = 4'd3;
    localparam logic [3:0] MODE_MAX        = 4'd8;

    typedef struct packed {
        logic [3:0] op;
        logic       ch;
    } msc_cmd_t;

endpackage

FILE: rtl/msc_ctrl.sv
// sequencer for channels, stages and stage steps
`timescale 1ns / 1ps
`include "multistage_slew_soft_clipper_assert.svh"
module msc_ctrl
    import msc_pkg::*;
#(
    parameter int STW = 3
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  logic [STW-1:0] last_stage,
    output logic [STW-1:0] stg,
    output msc_cmd_t       cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PHI   = 4'd1;
    localparam logic [3:0] ST_GAIN  = 4'd2;
    localparam logic [3:0] ST_CLAMP = 4'd3;
    localparam logic [3:0] ST_P1    = 4'd4;
    localparam logic [3:0] ST_P2    = 4'd5;
    localparam logic [3:0] ST_N1    = 4'd6;
    localparam logic [3:0] ST_N2    = 4'd7;
    localparam logic [3:0] ST_FIN1  = 4'd8;
    localparam logic [3:0] ST_FIN2  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [3:0]     state_reg, state_next;
    logic           ch_reg, ch_next;
    logic [STW-1:0] stg_reg, stg_next;
    logic           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        stg_next       = stg_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        cmd.ch         = ch_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    ch_next    = 1'b0;
                    state_next = ST_PHI;
                end
            end
            ST_PHI:
            begin
                cmd.op     = OP_PHI;
                stg_next   = '0;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.op     = OP_CLAMP;
                state_next = ST_P1;
            end
            ST_P1:
            begin
                cmd.op     = OP_P1;
                state_next = ST_P2;
            end
            ST_P2:
            begin
                cmd.op     = OP_P2;
                state_next = ST_N1;
            end
            ST_N1:
            begin
                cmd.op     = OP_N1;
                state_next = ST_N2;
            end
            ST_N2:
            begin
                cmd.op = OP_N2;
                if (stg_reg == last_stage)
                begin
                    state_next = ST_FIN1;
                end
                else
                begin
                    stg_next   = stg_reg + 1'b1;
                    state_next = ST_GAIN;
                end
            end
            ST_FIN1:
            begin
                cmd.op     = OP_FIN1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                cmd.op = OP_FIN2;
                if (!ch_reg)
                begin
                    ch_next    = 1'b1;
                    state_next = ST_PHI;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            stg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            stg_reg       <= stg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign stg       = stg_reg;

    `MSC_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == ST_PHI && !ch_reg, "transaction did not start left channel")
    `MSC_ASSERT_NXT(a_last_stage_ends, clk, rst_n, state_reg == ST_N2 && stg_reg == last_stage, state_reg == ST_FIN1, "stage loop overran")
    `MSC_ASSERT_IMP(a_stage_bound, clk, rst_n, state_reg != ST_IDLE && state_reg != ST_PHI, stg_reg <= last_stage, "stage index out of range")
    `MSC_ASSERT_NXT(a_result_loaded, clk, rst_n, state_reg == ST_OUT && (!out_valid_reg || out_ready), out_valid_reg && state_reg == ST_IDLE, "result not presented")

endmodule

FILE: rtl/msc_dp.sv
// datapath: shared rounding multiplier, stage state, delay lines, result registers
`timescale 1ns / 1ps
module msc_dp
    import msc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_STAGES  = 8,
    parameter int MAX_SPACING = 16,
    parameter int STW         = 3,
    parameter int SPW         = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  msc_cmd_t                      cmd,
    input  logic [STW-1:0]                stg,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  logic [19:0]                   gain,
    input  logic [16:0]                   recip,
    input  logic [16:0]                   ceil_scale,
    input  logic [SPW-1:0]                len_m1,
    input  logic                          mode_match,
    input  logic                          mode_over,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int XW = ((SAMPLE_BITS > STORE_W) ? SAMPLE_BITS : STORE_W) + 6;
    localparam int PW = XW + 22;
    localparam int SW = STORE_W;

    localparam logic signed [XW-1:0] K_ONE  = XW'(Q_ONE);
    localparam logic signed [XW-1:0] K_HARD = XW'(Q_HARD);
    localparam logic signed [XW-1:0] K_PHI  = XW'(Q_PHI);
    localparam logic signed [XW-1:0] K_FOUR = XW'(Q_FOUR);
    localparam logic signed [PW-1:0] HALF16 = PW'(32768);
    localparam logic signed [PW-1:0] HALF20 = PW'(524288);
    localparam logic signed [XW-1:0] SAT_HI = {{(XW-SAMPLE_BITS+1){1'b0}},
                                               {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = ~SAT_HI;

    logic signed [SAMPLE_BITS-1:0] in_l_reg, in_r_reg;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_r_reg;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_r_reg;
    logic signed [XW-1:0]          x_reg, last_reg, ov_reg;
    logic                          pflag_reg, nflag_reg;

    logic signed [SW-1:0] last_mem [2][MAX_STAGES];
    logic                 pclip [2][MAX_STAGES];
    logic                 nclip [2][MAX_STAGES];
    logic signed [SW-1:0] dline [2][MAX_STAGES][MAX_SPACING];

    logic signed [XW-1:0]          mul_a;
    logic [20:0]                   mul_b;
    logic                          sh20;
    logic signed [PW-1:0]          prod, rnd, shifted;
    logic signed [XW-1:0]          mr;
    logic signed [SAMPLE_BITS-1:0] in_sel;
    logic signed [SW-1:0]          last_rd;
    logic signed [XW-1:0]          cur_last, x_abs, x_cl, diff, x_sl, x_fin, sat_v;
    logic                          x_lt_last, x_gt_last, neg_hit;
    logic [SAMPLE_BITS-1:0]        sat_out;

    assign in_sel    = cmd.ch ? in_r_reg : in_l_reg;
    assign x_lt_last = x_reg < last_reg;
    assign x_gt_last = x_reg > last_reg;

    always_comb
    begin
        mul_a = x_reg;
        mul_b = '0;
        sh20  = 1'b0;
        unique case (cmd.op)
            OP_PHI:
            begin
                mul_a = {{(XW-SAMPLE_BITS){in_sel[SAMPLE_BITS-1]}}, in_sel};
                mul_b = 21'(Q_PHI);
                sh20  = 1'b1;
            end
            OP_GAIN:
            begin
                mul_b = {1'b0, gain};
            end
            OP_P1:
            begin
                mul_a = x_lt_last ? x_reg : last_reg;
                mul_b = x_lt_last ? 21'(Q_SOFT) : 21'(Q_HARD);
                sh20  = 1'b1;
            end
            OP_N1:
            begin
                mul_a = x_gt_last ? x_reg : last_reg;
                mul_b = x_gt_last ? 21'(Q_SOFT) : 21'(Q_HARD);
                sh20  = 1'b1;
            end
            OP_P2, OP_N2:
            begin
                mul_a = last_reg;
                mul_b = 21'(Q_SOFT);
                sh20  = 1'b1;
            end
            OP_FIN1:
            begin
                mul_b = {4'b0, recip};
            end
            OP_FIN2:
            begin
                mul_b = {4'b0, ceil_scale};
            end
            default:
            begin
                mul_b = '0;
            end
        endcase
    end

    // rounded product, ties toward plus infinity
    assign prod    = PW'(mul_a) * $signed({1'b0, mul_b});
    assign rnd     = prod + (sh20 ? HALF20 : HALF16);
    assign shifted = sh20 ? (rnd >>> 20) : (rnd >>> 16);
    assign mr      = shifted[XW-1:0];

    // clamp and slew limit
    assign last_rd  = last_mem[cmd.ch][stg];
    assign cur_last = {{(XW-SW){last_rd[SW-1]}}, last_rd};
    assign x_abs    = x_reg[XW-1] ? -x_reg : x_reg;

    always_comb
    begin
        if (x_reg > K_FOUR)
        begin
            x_cl = K_FOUR;
        end
        else if (x_reg < -K_FOUR)
        begin
            x_cl = -K_FOUR;
        end
        else
        begin
            x_cl = x_reg;
        end
        diff = x_cl - cur_last;
        if (diff > K_HARD)
        begin
            x_sl = cur_last + K_HARD;
        end
        else if (diff < -K_HARD)
        begin
            x_sl = cur_last - K_HARD;
        end
        else
        begin
            x_sl = x_cl;
        end
    end

    assign neg_hit = x_reg < -K_PHI;
    assign x_fin   = neg_hit ? (mr - K_ONE) : x_reg;

    always_comb
    begin
        if (mr > SAT_HI)
        begin
            sat_v = SAT_HI;
        end
        else if (mr < SAT_LO)
        begin
            sat_v = SAT_LO;
        end
        else
        begin
            sat_v = mr;
        end
    end
    assign sat_out = sat_v[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                in_l_reg <= left_sample;
                in_r_reg <= right_sample;
            end
            OP_PHI, OP_GAIN:
            begin
                x_reg <= mr;
            end
            OP_CLAMP:
            begin
                if (stg == '0)
                begin
                    ov_reg <= (x_abs > K_PHI) ? (x_abs - K_PHI) : '0;
                end
                x_reg     <= x_sl;
                last_reg  <= cur_last;
                pflag_reg <= pclip[cmd.ch][stg];
                nflag_reg <= nclip[cmd.ch][stg];
            end
            OP_P1:
            begin
                if (pflag_reg)
                begin
                    last_reg <= (x_lt_last ? K_ONE : K_HARD) + mr;
                end
            end
            OP_P2:
            begin
                if (x_reg > K_PHI)
                begin
                    x_reg <= K_ONE + mr;
                end
            end
            OP_N1:
            begin
                if (nflag_reg)
                begin
                    last_reg <= mr - (x_gt_last ? K_ONE : K_HARD);
                end
            end
            OP_N2:
            begin
                x_reg <= last_reg;
            end
            OP_FIN1:
            begin
                if (mode_match)
                begin
                    x_reg <= mr;
                end
                else if (mode_over)
                begin
                    x_reg <= ov_reg;
                end
            end
            OP_FIN2:
            begin
                if (cmd.ch)
                begin
                    res_r_reg <= sat_out;
                end
                else
                begin
                    res_l_reg <= sat_out;
                end
            end
            OP_OUT:
            begin
                out_l_reg <= res_l_reg;
                out_r_reg <= res_r_reg;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    for (genvar c = 0; c < 2; c++)
    begin : g_ch
        for (genvar s = 0; s < MAX_STAGES; s++)
        begin : g_stage
            logic hit;
            assign hit = (cmd.ch == c[0]) && (stg == STW'(s));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pclip[c][s]    <= 1'b0;
                    nclip[c][s]    <= 1'b0;
                    last_mem[c][s] <= '0;
                end
                else if (hit && cmd.op == OP_P2)
                begin
                    pclip[c][s] <= x_reg > K_PHI;
                end
                else if (hit && cmd.op == OP_N2)
                begin
                    nclip[c][s] <= neg_hit;
                    if (len_m1 == '0 || MAX_SPACING == 1)
                    begin
                        last_mem[c][s] <= x_fin[SW-1:0];
                    end
                    else
                    begin
                        last_mem[c][s] <= dline[c][s][(MAX_SPACING > 1) ? 1 : 0];
                    end
                end
            end

            for (genvar i = 0; i < MAX_SPACING; i++)
            begin : g_tap
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        dline[c][s][i] <= '0;
                    end
                    else if (hit && cmd.op == OP_N2)
                    begin
                        if (len_m1 == SPW'(i))
                        begin
                            dline[c][s][i] <= x_fin[SW-1:0];
                        end
                        else if (SPW'(i) < len_m1)
                        begin
                            dline[c][s][i] <=
                                dline[c][s][(i < MAX_SPACING - 1) ? i + 1 : i];
                        end
                    end
                end
            end
        end
    end

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

endmodule

FILE: rtl/multistage_slew_soft_clipper.sv
// top level: configuration registers, sequencer and datapath
//
//  channel | signals                               | direction
//  input   | in_valid, in_ready, left/right_sample | frame in
//  output  | out_valid, out_ready, left/right_out  | frame out
//  config  | psel, penable, pwrite, paddr, pwdata  | register access
//
// the number of active stages runs from 1 to 6, set by the clip mode
// each stage runs six steps per channel on one shared rounding multiplier
// the result register lets the next frame start while a result is held
// a new frame is taken only once the previous result has been loaded out
// reset sets the config registers to defaults and clears clip flags, last samples and delay lines
`timescale 1ns / 1ps
module multistage_slew_soft_clipper
    import msc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_STAGES  = 8,
    parameter int MAX_SPACING = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int STW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int SPW = (MAX_SPACING > 1) ? $clog2(MAX_SPACING) : 1;

    logic [19:0] gain_reg;
    logic [16:0] recip_reg;
    logic [16:0] ceil_reg;
    logic [3:0]  mode_reg;
    logic [4:0]  spacing_reg;

    logic [2:0]     reg_idx;
    logic           wr_en;
    logic [3:0]     mode_eff, ls4;
    logic [STW-1:0] last_stage, stg;
    logic [4:0]     len5;
    logic [SPW-1:0] len_m1;
    msc_cmd_t       cmd;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= 20'd65536;
            recip_reg   <= 17'd65536;
            ceil_reg    <= 17'd32768;
            mode_reg    <= 4'd1;
            spacing_reg <= 5'd1;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_STAGE_GAIN: gain_reg    <= pwdata[19:0];
                REG_GAIN_RECIP: recip_reg   <= pwdata[16:0];
                REG_CEILING:    ceil_reg    <= pwdata[16:0];
                REG_CLIP_MODE:  mode_reg    <= pwdata[3:0];
                REG_SPACING:    spacing_reg <= pwdata[4:0];
                default:        gain_reg    <= gain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_STAGE_GAIN: prdata = {12'd0, gain_reg};
            REG_GAIN_RECIP: prdata = {15'd0, recip_reg};
            REG_CEILING:    prdata = {15'd0, ceil_reg};
            REG_CLIP_MODE:  prdata = {28'd0, mode_reg};
            REG_SPACING:    prdata = {27'd0, spacing_reg};
            default:        prdata = '0;
        endcase
    end

    assign mode_eff   = (mode_reg > MODE_MAX) ? MODE_MAX : mode_reg;
    assign ls4        = (mode_eff > MODE_OVERSHOOT) ? (mode_eff - MODE_OVERSHOOT) : 4'd0;
    assign last_stage = (ls4 > 4'(MAX_STAGES - 1)) ? STW'(MAX_STAGES - 1) : STW'(ls4);

    always_comb
    begin
        if (spacing_reg == 5'd0)
        begin
            len5 = 5'd0;
        end
        else if (spacing_reg > 5'(MAX_SPACING))
        begin
            len5 = 5'(MAX_SPACING - 1);
        end
        else
        begin
            len5 = spacing_reg - 5'd1;
        end
    end
    assign len_m1 = len5[SPW-1:0];

    msc_ctrl #(
        .STW (STW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .last_stage (last_stage),
        .stg        (stg),
        .cmd        (cmd)
    );

    msc_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_STAGES  (MAX_STAGES),
        .MAX_SPACING (MAX_SPACING),
        .STW         (STW),
        .SPW         (SPW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stg          (stg),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .gain         (gain_reg),
        .recip        (recip_reg),
        .ceil_scale   (ceil_reg),
        .len_m1       (len_m1),
        .mode_match   (mode_eff == MODE_GAIN_MATCH),
        .mode_over    (mode_eff == MODE_OVERSHOOT),
        .left_out     (left_out),
        .right_out    (right_out)
    );

endmodule
